### hdl/ppp_pkg.sv
// shared types, widths and register codes for the point to plane projection block
package ppp_pkg;

    // field and arithmetic widths
    localparam int PW            = 32;          // coordinate width
    localparam int FRAC_BITS_DEF = 16;          // default fraction bits
    localparam int NUMW          = 67;          // signed width of numerator and denominator
    localparam int ABW           = 66;          // magnitude width of numerator and denominator
    localparam int MAGW          = ABW + PW;    // |num| * |v|
    localparam int NW            = MAGW + 2;    // 2*mag + |den|
    localparam int DW            = ABW + 2;     // 2*|den|
    localparam int QB            = 34;          // quotient bits kept before saturation
    localparam int CW            = DW + QB;     // divider remainder width
    localparam int QDEPTH        = 2;           // front to back queue depth
    localparam int CFG_IW        = 8;           // register index width

    // register indexes
    localparam logic [CFG_IW-1:0] REG_PLANE_NX     = 8'd0;
    localparam logic [CFG_IW-1:0] REG_PLANE_NY     = 8'd1;
    localparam logic [CFG_IW-1:0] REG_PLANE_NZ     = 8'd2;
    localparam logic [CFG_IW-1:0] REG_PLANE_OFFSET = 8'd3;

    // register reset values
    localparam logic [PW-1:0] NZ_RESET = 32'h0001_0000;

    // input item
    typedef struct packed {
        logic          mode;
        logic [PW-1:0] point_x;
        logic [PW-1:0] point_y;
        logic [PW-1:0] point_z;
        logic [PW-1:0] dir_x;
        logic [PW-1:0] dir_y;
        logic [PW-1:0] dir_z;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [PW-1:0] proj_x;
        logic [PW-1:0] proj_y;
        logic [PW-1:0] proj_z;
        logic          parallel;
        logic          clipped;
    } out_item_t;

    // plane held in configuration
    typedef struct packed {
        logic [PW-1:0] nx;
        logic [PW-1:0] ny;
        logic [PW-1:0] nz;
        logic [PW-1:0] offset;
    } plane_t;

    // classified item passed from front to back
    typedef struct packed {
        logic                   parallel;
        logic [2:0]             neg;
        logic [2:0][PW-1:0]     p;
        logic [2:0][NW-1:0]     n_val;
        logic [DW-1:0]          d_val;
    } job_t;

    // divider pipeline stage
    typedef struct packed {
        logic                   valid;
        logic                   parallel;
        logic [2:0]             ovf;
        logic [2:0]             neg;
        logic [2:0][PW-1:0]     p;
        logic [2:0][CW-1:0]     r;
        logic [2:0][QB-1:0]     q;
        logic [DW-1:0]          d_val;
    } div_t;

endpackage

### hdl/project_point_to_plane_top.sv
// top level of the point to plane projection block
//
// Projects a signed fixed point 3D point onto the plane n.x + d = 0 held in
// four configuration registers, along the normal (mode 0) or along a given
// direction (mode 1).
// Input: an item is taken at a rising edge with start high and busy low.
// Configuration: cfg_valid, cfg_index, cfg_data; cfg_ready is always high and
// unknown indexes are ignored. Write only while no item is in flight.
// Output: each result is on result for exactly one cycle with done high.
// Throughput: one item per cycle, sustained; the multiply front end and the
// bit-per-stage divider are both fully pipelined.
// Path: an accepted item passes six front stages, the queue, the range check,
// 34 quotient stages and the clamp register; done rises with its result.
// busy only rises if the internal queue fills, which the back end drains
// every cycle, so in practice it stays low.
// Reset: asynchronous, clears all pipeline valid flags and loads the plane
// with normal (0, 0, 1.0) and offset 0.
module project_point_to_plane_top #(
    parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  ppp_pkg::in_item_t           item,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ppp_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [ppp_pkg::PW-1:0]      cfg_data,
    output logic                        done,
    output ppp_pkg::out_item_t          result
);

    ppp_pkg::plane_t plane_reg;
    ppp_pkg::plane_t plane_next;
    ppp_pkg::job_t   push_job;
    ppp_pkg::job_t   pop_job;
    logic            push;
    logic            not_empty;
    logic            full;
    logic            accept;

    assign cfg_ready = 1'b1;
    assign busy      = full;
    assign accept    = start && !busy;

    // configuration register write
    always_comb
    begin
        plane_next = plane_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                ppp_pkg::REG_PLANE_NX:     plane_next.nx     = cfg_data;
                ppp_pkg::REG_PLANE_NY:     plane_next.ny     = cfg_data;
                ppp_pkg::REG_PLANE_NZ:     plane_next.nz     = cfg_data;
                ppp_pkg::REG_PLANE_OFFSET: plane_next.offset = cfg_data;
                default:                   plane_next        = plane_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg.nx     <= '0;
            plane_reg.ny     <= '0;
            plane_reg.nz     <= ppp_pkg::NZ_RESET;
            plane_reg.offset <= '0;
        end
        else
        begin
            plane_reg <= plane_next;
        end
    end

    // front end
    ppp_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .plane  (plane_reg),
        .push   (push),
        .job    (push_job)
    );

    // decoupling queue
    ppp_queue #(
        .DEPTH (ppp_pkg::QDEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_job    (push_job),
        .pop       (not_empty),
        .not_empty (not_empty),
        .full      (full),
        .rd_job    (pop_job)
    );

    // back end
    ppp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (not_empty),
        .job       (pop_job),
        .done      (done),
        .result    (result)
    );

endmodule

### hdl/ppp_front.sv
// front end: dot products, classification and correction magnitudes
module ppp_front #(
    parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  ppp_pkg::in_item_t item,
    input  ppp_pkg::plane_t   plane,
    output logic              push,
    output ppp_pkg::job_t     job
);

    localparam int PW   = ppp_pkg::PW;
    localparam int NUMW = ppp_pkg::NUMW;
    localparam int ABW  = ppp_pkg::ABW;
    localparam int MAGW = ppp_pkg::MAGW;
    localparam int NW   = ppp_pkg::NW;

    // stage 1: registered point, direction and normal
    logic                 s1_valid_reg;
    logic signed [PW-1:0] s1_p_reg [3];
    logic signed [PW-1:0] s1_v_reg [3];
    logic signed [PW-1:0] s1_n_reg [3];
    logic signed [PW-1:0] s1_off_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_p_reg[0] <= item.point_x;
        s1_p_reg[1] <= item.point_y;
        s1_p_reg[2] <= item.point_z;
        s1_n_reg[0] <= plane.nx;
        s1_n_reg[1] <= plane.ny;
        s1_n_reg[2] <= plane.nz;
        s1_off_reg  <= plane.offset;
        s1_v_reg[0] <= item.mode ? item.dir_x : plane.nx;
        s1_v_reg[1] <= item.mode ? item.dir_y : plane.ny;
        s1_v_reg[2] <= item.mode ? item.dir_z : plane.nz;
    end

    // stage 2: products against the normal
    logic                   s2_valid_reg;
    logic signed [2*PW-1:0] s2_pn_reg [3];
    logic signed [2*PW-1:0] s2_vn_reg [3];
    logic signed [NUMW-1:0] s2_off_reg;
    logic signed [PW-1:0]   s2_p_reg [3];
    logic signed [PW-1:0]   s2_v_reg [3];
    logic        [NUMW-1:0] off_ext;

    assign off_ext = {{(NUMW-PW){s1_off_reg[PW-1]}}, s1_off_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_pn_reg[i] <= s1_p_reg[i] * s1_n_reg[i];
            s2_vn_reg[i] <= s1_v_reg[i] * s1_n_reg[i];
            s2_p_reg[i]  <= s1_p_reg[i];
            s2_v_reg[i]  <= s1_v_reg[i];
        end
        s2_off_reg <= off_ext << FRAC_BITS;
    end

    // stage 3: numerator and denominator sums
    logic                   s3_valid_reg;
    logic signed [NUMW-1:0] s3_num_reg;
    logic signed [NUMW-1:0] s3_den_reg;
    logic signed [PW-1:0]   s3_p_reg [3];
    logic signed [PW-1:0]   s3_v_reg [3];
    logic signed [NUMW-1:0] pn_ext [3];
    logic signed [NUMW-1:0] vn_ext [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pn_ext[i] = {{(NUMW-2*PW){s2_pn_reg[i][2*PW-1]}}, s2_pn_reg[i]};
            vn_ext[i] = {{(NUMW-2*PW){s2_vn_reg[i][2*PW-1]}}, s2_vn_reg[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_num_reg <= s2_off_reg + pn_ext[0] + pn_ext[1] + pn_ext[2];
        s3_den_reg <= vn_ext[0] + vn_ext[1] + vn_ext[2];
        for (int i = 0; i < 3; i++)
        begin
            s3_p_reg[i] <= s2_p_reg[i];
            s3_v_reg[i] <= s2_v_reg[i];
        end
    end

    // stage 4: magnitudes, signs and the parallel check
    logic                 s4_valid_reg;
    logic [ABW-1:0]       s4_absnum_reg;
    logic [ABW-1:0]       s4_absden_reg;
    logic [2:0]           s4_neg_reg;
    logic                 s4_parallel_reg;
    logic [PW-1:0]        s4_absv_reg [3];
    logic [PW-1:0]        s4_p_reg [3];
    logic [NUMW-1:0]      num_mag;
    logic [NUMW-1:0]      den_mag;
    logic                 quot_neg;

    assign num_mag  = s3_num_reg[NUMW-1] ? NUMW'(-s3_num_reg) : NUMW'(s3_num_reg);
    assign den_mag  = s3_den_reg[NUMW-1] ? NUMW'(-s3_den_reg) : NUMW'(s3_den_reg);
    assign quot_neg = s3_num_reg[NUMW-1] ^ s3_den_reg[NUMW-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_absnum_reg   <= num_mag[ABW-1:0];
        s4_absden_reg   <= den_mag[ABW-1:0];
        s4_parallel_reg <= (s3_den_reg == '0);
        for (int i = 0; i < 3; i++)
        begin
            s4_absv_reg[i] <= s3_v_reg[i][PW-1] ? PW'(~s3_v_reg[i] + 1'b1) : s3_v_reg[i];
            s4_neg_reg[i]  <= s3_v_reg[i][PW-1] ^ quot_neg;
            s4_p_reg[i]    <= s3_p_reg[i];
        end
    end

    // stage 5: partial products of |num| times |v|
    logic                 s5_valid_reg;
    logic [2*PW-1:0]      s5_pp_lo_reg  [3];
    logic [2*PW-1:0]      s5_pp_mid_reg [3];
    logic [ABW-PW-1:0]    s5_pp_hi_reg  [3];
    logic [ABW-1:0]       s5_absden_reg;
    logic [2:0]           s5_neg_reg;
    logic                 s5_parallel_reg;
    logic [PW-1:0]        s5_p_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s5_pp_lo_reg[i]  <= s4_absnum_reg[PW-1:0] * s4_absv_reg[i];
            s5_pp_mid_reg[i] <= s4_absnum_reg[2*PW-1:PW] * s4_absv_reg[i];
            s5_pp_hi_reg[i]  <= s4_absnum_reg[ABW-1:2*PW] * s4_absv_reg[i];
            s5_p_reg[i]      <= s4_p_reg[i];
        end
        s5_absden_reg   <= s4_absden_reg;
        s5_neg_reg      <= s4_neg_reg;
        s5_parallel_reg <= s4_parallel_reg;
    end

    // stage 6: full magnitude products
    logic                 s6_valid_reg;
    logic [MAGW-1:0]      s6_mag_reg [3];
    logic [ABW-1:0]       s6_absden_reg;
    logic [2:0]           s6_neg_reg;
    logic                 s6_parallel_reg;
    logic [PW-1:0]        s6_p_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s6_mag_reg[i] <= (MAGW'(s5_pp_hi_reg[i]) << (2*PW))
                           + (MAGW'(s5_pp_mid_reg[i]) << PW)
                           + MAGW'(s5_pp_lo_reg[i]);
            s6_p_reg[i]   <= s5_p_reg[i];
        end
        s6_absden_reg   <= s5_absden_reg;
        s6_neg_reg      <= s5_neg_reg;
        s6_parallel_reg <= s5_parallel_reg;
    end

    // rounded dividend 2*mag + |den| and divisor 2*|den|
    always_comb
    begin
        job.parallel = s6_parallel_reg;
        job.neg      = s6_neg_reg;
        job.d_val    = {1'b0, s6_absden_reg, 1'b0};
        for (int i = 0; i < 3; i++)
        begin
            job.p[i]     = s6_p_reg[i];
            job.n_val[i] = {1'b0, s6_mag_reg[i], 1'b0} + NW'(s6_absden_reg);
        end
    end

    assign push = s6_valid_reg;

endmodule

### hdl/ppp_queue.sv
// short queue between the front end and the divider back end
module ppp_queue #(
    parameter int DEPTH = ppp_pkg::QDEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ppp_pkg::job_t wr_job,
    input  logic          pop,
    output logic          not_empty,
    output logic          full,
    output ppp_pkg::job_t rd_job
);

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    ppp_pkg::job_t   entry_reg [DEPTH];
    logic [PTRW-1:0] wr_ptr_reg;
    logic [PTRW-1:0] wr_ptr_next;
    logic [PTRW-1:0] rd_ptr_reg;
    logic [PTRW-1:0] rd_ptr_next;
    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] count_next;
    logic            do_push;
    logic            do_pop;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNTW'(DEPTH));
    assign do_pop    = pop && not_empty;
    assign do_push   = push && (!full || do_pop);
    assign rd_job    = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

    // no item is dropped at the write side
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || do_pop))
        else $error("queue push while full");

endmodule

### hdl/ppp_back.sv
// back end: pipelined restoring division, rounding correction and saturation
module ppp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    input  ppp_pkg::job_t      job,
    output logic               done,
    output ppp_pkg::out_item_t result
);

    localparam int PW = ppp_pkg::PW;
    localparam int QB = ppp_pkg::QB;
    localparam int CW = ppp_pkg::CW;

    ppp_pkg::div_t st_reg [QB+1];
    ppp_pkg::div_t st_next0;
    logic [CW-1:0] ovf_lim;

    // entry stage: quotient range check and remainder load
    assign ovf_lim = CW'(job.d_val) << QB;

    always_comb
    begin
        st_next0.valid    = job_valid;
        st_next0.parallel = job.parallel;
        st_next0.neg      = job.neg;
        st_next0.p        = job.p;
        st_next0.d_val    = job.d_val;
        for (int i = 0; i < 3; i++)
        begin
            st_next0.r[i]   = CW'(job.n_val[i]);
            st_next0.q[i]   = '0;
            st_next0.ovf[i] = (CW'(job.n_val[i]) >= ovf_lim);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg[0] <= '0;
        end
        else
        begin
            st_reg[0] <= st_next0;
        end
    end

    // one quotient bit per stage, three lanes side by side
    for (genvar j = 0; j < QB; j++)
    begin : g_div
        localparam int K = QB - 1 - j;
        ppp_pkg::div_t st_next;
        logic [CW-1:0] sub;

        assign sub = CW'(st_reg[j].d_val) << K;

        always_comb
        begin
            st_next = st_reg[j];
            for (int i = 0; i < 3; i++)
            begin
                if (st_reg[j].r[i] >= sub)
                begin
                    st_next.r[i]    = st_reg[j].r[i] - sub;
                    st_next.q[i][K] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                st_reg[j+1] <= '0;
            end
            else
            begin
                st_reg[j+1] <= st_next;
            end
        end
    end

    // apply the correction and clamp each coordinate, or pass the point through for a parallel item
    logic signed [PW+3:0] p_ext   [3];
    logic signed [PW+3:0] q_ext   [3];
    logic signed [PW+3:0] sum     [3];
    logic        [PW-1:0] coord   [3];
    logic        [2:0]    clip;
    ppp_pkg::out_item_t   result_next;
    ppp_pkg::div_t        fin;

    assign fin = st_reg[QB];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_ext[i] = {{4{fin.p[i][PW-1]}}, fin.p[i]};
            q_ext[i] = {2'b00, fin.q[i]};
            sum[i]   = fin.neg[i] ? p_ext[i] + q_ext[i] : p_ext[i] - q_ext[i];
            clip[i]  = 1'b0;
            coord[i] = sum[i][PW-1:0];
            if (fin.ovf[i])
            begin
                clip[i]  = 1'b1;
                coord[i] = fin.neg[i] ? {1'b0, {(PW-1){1'b1}}} : {1'b1, {(PW-1){1'b0}}};
            end
            else if (sum[i][PW+3:PW-1] != {5{sum[i][PW+3]}})
            begin
                clip[i]  = 1'b1;
                coord[i] = sum[i][PW+3] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
            end
            if (fin.parallel)
            begin
                clip[i]  = 1'b0;
                coord[i] = fin.p[i];
            end
        end
        result_next.proj_x   = coord[0];
        result_next.proj_y   = coord[1];
        result_next.proj_z   = coord[2];
        result_next.parallel = fin.parallel;
        result_next.clipped  = |clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= fin.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result <= result_next;
    end

    // every item entering the divider leaves after a fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg[0].valid |-> ##(QB+1) done)
        else $error("item lost in divider pipeline");

    // a parallel item never reports saturation
    a_parallel_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.parallel) |-> !result.clipped)
        else $error("parallel item flagged as clipped");

endmodule

### sim/project_point_to_plane_top_tb.sv
// testbench for the point to plane projection block: scoreboard, stimulus and checks
`timescale 1ns / 100ps

module project_point_to_plane_top_tb;

    // scoreboard holding the predicted projections
    class projection_board;
        ppp_pkg::out_item_t pending[$];
        int        errors;
        logic signed [31:0] nx, ny, nz, off;

        function new();
            errors = 0;
            nx = 0;
            ny = 0;
            nz = 32'sh0001_0000;
            off = 0;
        endfunction

        function void set_reg(logic [ppp_pkg::CFG_IW-1:0] idx, logic [31:0] val);
            case (idx)
                ppp_pkg::REG_PLANE_NX:     nx = val;
                ppp_pkg::REG_PLANE_NY:     ny = val;
                ppp_pkg::REG_PLANE_NZ:     nz = val;
                ppp_pkg::REG_PLANE_OFFSET: off = val;
                default: ;
            endcase
        endfunction

        // predicted projection of one item
        function ppp_pkg::out_item_t project(ppp_pkg::in_item_t it);
            logic signed [31:0]  p[3], v[3], n[3];
            logic signed [127:0] num, den, prod, mag, adn, q, corr, res;
            logic [31:0]         o[3];
            ppp_pkg::out_item_t  r;
            logic                clip;
            n[0] = nx;
            n[1] = ny;
            n[2] = nz;
            p[0] = it.point_x;
            p[1] = it.point_y;
            p[2] = it.point_z;
            v[0] = it.mode ? it.dir_x : nx;
            v[1] = it.mode ? it.dir_y : ny;
            v[2] = it.mode ? it.dir_z : nz;
            num = 128'(off) <<< 16;
            den = 0;
            for (int i = 0; i < 3; i++)
            begin
                num = num + 128'(p[i]) * 128'(n[i]);
                den = den + 128'(v[i]) * 128'(n[i]);
            end
            clip = 0;
            if (den == 0)
            begin
                r.proj_x = p[0];
                r.proj_y = p[1];
                r.proj_z = p[2];
                r.parallel = 1;
                r.clipped = 0;
                return r;
            end
            adn = den < 0 ? -den : den;
            for (int i = 0; i < 3; i++)
            begin
                // round half away from zero on the magnitude
                prod = num * 128'(v[i]);
                mag = prod < 0 ? -prod : prod;
                q = (2 * mag + adn) / (2 * adn);
                corr = ((prod < 0) != (den < 0)) ? -q : q;
                res = 128'(p[i]) - corr;
                if (res > 128'sh7FFF_FFFF)
                begin
                    o[i] = 32'h7FFF_FFFF;
                    clip = 1;
                end
                else if (res < -128'sh8000_0000)
                begin
                    o[i] = 32'h8000_0000;
                    clip = 1;
                end
                else
                    o[i] = res[31:0];
            end
            r.proj_x = o[0];
            r.proj_y = o[1];
            r.proj_z = o[2];
            r.parallel = 0;
            r.clipped = clip;
            return r;
        endfunction

        function void note_item(ppp_pkg::in_item_t it);
            pending.push_back(project(it));
        endfunction

        function void check_result(ppp_pkg::out_item_t got);
            ppp_pkg::out_item_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.proj_x !== want.proj_x)
            begin
                $display("%0t: proj_x expected %h actual %h", $time, want.proj_x, got.proj_x);
                errors++;
            end
            if (got.proj_y !== want.proj_y)
            begin
                $display("%0t: proj_y expected %h actual %h", $time, want.proj_y, got.proj_y);
                errors++;
            end
            if (got.proj_z !== want.proj_z)
            begin
                $display("%0t: proj_z expected %h actual %h", $time, want.proj_z, got.proj_z);
                errors++;
            end
            if (got.parallel !== want.parallel)
            begin
                $display("%0t: parallel expected %b actual %b", $time, want.parallel,
                         got.parallel);
                errors++;
            end
            if (got.clipped !== want.clipped)
            begin
                $display("%0t: clipped expected %b actual %b", $time, want.clipped,
                         got.clipped);
                errors++;
            end
        endfunction
    endclass

    localparam int LATENCY = 43;
    localparam int CYCLE_LIMIT = 400000;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    ppp_pkg::in_item_t            item;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [ppp_pkg::CFG_IW-1:0]   cfg_index;
    logic [ppp_pkg::PW-1:0]       cfg_data;
    logic                         done;
    ppp_pkg::out_item_t           result;

    projection_board board;
    int              cycles;

    project_point_to_plane_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    // clock
    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // result checking and timeout
    initial
    begin
        board = new();
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (rst_n && done)
                board.check_result(result);
            if (cycles > CYCLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // random coordinate, biased towards extremes and modest values
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3, 4: return $urandom;
            default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    // one register write; the caller drops cfg_valid after the last one
    task automatic write_reg(input logic [ppp_pkg::CFG_IW-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        board.set_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic send_item(input ppp_pkg::in_item_t it);
        start <= 1;
        item  <= it;
        do @(posedge clk); while (busy);
        board.note_item(it);
        @(negedge clk);
    endtask

    // wait for all results, then let the pipeline settle
    task automatic drain();
        start <= 0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic set_plane(input logic [31:0] a, b, c, d);
        write_reg(ppp_pkg::REG_PLANE_NX, a);
        write_reg(ppp_pkg::REG_PLANE_NY, b);
        write_reg(ppp_pkg::REG_PLANE_NZ, c);
        write_reg(ppp_pkg::REG_PLANE_OFFSET, d);
        cfg_valid <= 0;
    endtask

    function automatic ppp_pkg::in_item_t rand_item();
        ppp_pkg::in_item_t it;
        it.mode = $urandom_range(0, 1);
        it.point_x = rand_coord();
        it.point_y = rand_coord();
        it.point_z = rand_coord();
        it.dir_x = rand_coord();
        it.dir_y = rand_coord();
        it.dir_z = rand_coord();
        return it;
    endfunction

    task automatic random_phase(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 30);
            for (int i = 0; i < burst && sent < count; i++)
            begin
                send_item(rand_item());
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                start <= 0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
    endtask

    // stimulus
    initial
    begin
        ppp_pkg::in_item_t it;
        rst_n = 0;
        start = 0;
        item = '0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (11) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // reset plane z = 0: simple points, extremes, mode 1 with parallel direction
        it = '0;
        it.point_z = 32'h0003_0000;
        send_item(it);
        it = '{1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0};
        send_item(it);
        it = '{1'b1, 32'h1_0000, 32'h2_0000, 32'h5_0000, 32'h1_0000, 32'h0, 32'h0};
        send_item(it);
        it = '{1'b1, 32'h1_0000, 32'h2_0000, 32'h5_0000, 32'h1_0000, 32'h0, 32'h1};
        send_item(it);
        it = '{1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        send_item(it);
        it = '{1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        send_item(it);
        it = '{1'b1, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0000_0001};
        send_item(it);
        for (int i = 0; i < 6; i++)
            send_item(rand_item());
        drain();

        // all-zero normal: everything parallel
        set_plane(32'h0, 32'h0, 32'h0, 32'h1234_5678);
        for (int i = 0; i < 5; i++)
            send_item(rand_item());
        drain();

        // extreme plane values, clipping likely
        set_plane(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        for (int i = 0; i < 8; i++)
            send_item(rand_item());
        drain();

        // random phases across several planes, extremes included
        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph % 3)
                0: set_plane(32'h1_0000, 32'h0, 32'h0, 32'hFFFE_0000);
                1: set_plane(rand_coord(), rand_coord(), rand_coord(), rand_coord());
                default: set_plane(32'($signed($urandom_range(0, 400000)) - 200000),
                                   32'($signed($urandom_range(0, 400000)) - 200000),
                                   32'($signed($urandom_range(0, 400000)) - 200000),
                                   $urandom);
            endcase
            random_phase(200);
            drain();
        end
        // restore reset plane for a last stretch
        set_plane(32'h0, 32'h0, 32'h0001_0000, 32'h0);
        random_phase(30);
        drain();

        if (board.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
